// ----- rtl/faf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faf_pkg
// types and constants shared by the first-fit allocator files
// ----------------------------------------------------------------------------
package faf_pkg;

  localparam int ADDR_W    = 32;
  localparam int CNT_OUT_W = 7;

  localparam logic [ADDR_W-1:0] PAGE_ADD  = 32'h0000_0fff;
  localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hffff_f000;
  localparam logic [ADDR_W-1:0] SAT32     = 32'hffff_ffff;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } entry_t;

  typedef struct packed {
    entry_t ent;
    logic   valid;
  } qent_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SUM,
    S_OUT
  } state_t;

  function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_W] ? SAT32 : s[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/faf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faf_req_if / faf_rsp_if
// valid/ready channels for allocator requests and results
// ----------------------------------------------------------------------------
interface faf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] block_address;
  logic [31:0] block_size;
  logic        page_round;

  modport source (output valid, operation, block_address, block_size, page_round,
                  input ready);
  modport sink (input valid, operation, block_address, block_size, page_round,
                output ready);
endinterface

interface faf_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] granted_address;
  logic [31:0] free_total;
  logic [6:0]  entries_used;
  logic [6:0]  peak_entries;
  logic [31:0] lost_blocks;
  logic [31:0] lost_bytes;

  modport source (output valid, status, granted_address, free_total, entries_used,
                  peak_entries, lost_blocks, lost_bytes, input ready);
  modport sink (input valid, status, granted_address, free_total, entries_used,
                peak_entries, lost_blocks, lost_bytes, output ready);
endinterface

// ----- rtl/faf_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faf_cell
// one free-region entry of the shifting table
// ----------------------------------------------------------------------------
module faf_cell (
  input  logic            clk,
  input  logic            shift,
  input  faf_pkg::entry_t din,
  output faf_pkg::entry_t dout
);
  import faf_pkg::*;

  entry_t ent;

  always_ff @(posedge clk) begin
    if (shift) begin
      ent <= din;
    end
  end

  assign dout = ent;

endmodule

// ----- rtl/first_fit_free_list_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// first-fit allocator over an address-sorted, coalescing free-region table
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | operation, block_address, block_size, page_round
//  rsp     | out | valid/ready | status, granted_address, free_total, entries_used,
//          |     |             | peak_entries, lost_blocks, lost_bytes
//
//  one item at a time: the result waits on one full rotation of the cell
//  chain past the head plus a final sum step; req.ready is high only when
//  no item is in work.
//  reset clears the entry count and counters; the cells need no clearing.
//  a result waits in its output register as long as rsp.ready is low.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic clk,
  input  logic rst,
  faf_req_if.sink   req,
  faf_rsp_if.source rsp
);
  import faf_pkg::*;

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES);

  state_t state, state_next;

  // cell chain: each step of a pass shifts every entry one cell toward the head and
  // the controller pushes the rebuilt entry stream in at the tail
  entry_t cell_q [TABLE_ENTRIES];
  entry_t tail;
  logic   shift;

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      if (g == TABLE_ENTRIES - 1) begin : g_tail
        faf_cell u_cell (.clk(clk), .shift(shift), .din(tail), .dout(cell_q[g]));
      end else begin : g_mid
        faf_cell u_cell (.clk(clk), .shift(shift), .din(cell_q[g+1]), .dout(cell_q[g]));
      end
    end
  endgenerate

  // item registers
  logic [1:0]        op;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] size;

  // pass control
  logic [CW-1:0]     step;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     new_cnt;
  logic [CW-1:0]     peak;
  logic              done;
  logic [1:0]        status;
  logic [ADDR_W-1:0] grant;

  // reorder queue between head and tail, at most two held entries
  qent_t q0, q1;
  logic [1:0] qn;

  // registered copy of the tail length for the running free total
  logic [ADDR_W-1:0] acc_len;
  logic              acc_v;
  logic [ADDR_W-1:0] sum;

  logic [ADDR_W-1:0] lost_n, lost_b;

  // output register
  logic              out_v;
  logic [1:0]        o_status;
  logic [ADDR_W-1:0] o_grant, o_sum, o_lost_n, o_lost_b;
  logic [CW-1:0]     o_cnt, o_peak;

  logic [ADDR_W-1:0] size_in;
  assign size_in = req.page_round ? ((req.block_size + PAGE_ADD) & PAGE_MASK)
                                  : req.block_size;

  logic accept;
  assign accept = req.valid && req.ready;

  // head evaluation and queue rebuild
  entry_t h;
  logic   hv, have_add, pop;
  qent_t  q0m, p0, p1;
  logic [1:0] pn;
  logic [2:0] ln;
  qent_t  lst [4];
  logic   dec_done, dec_lost, cnt_dec, cnt_inc, set_grant;
  logic [1:0] dec_status;
  logic   at_pos, prevm, nextm;

  always_comb begin
    h          = cell_q[0];
    hv         = step < cnt;
    have_add   = step < LAST;
    pop        = step != '0;
    q0m        = q0;
    p0         = '{ent: h, valid: hv};
    p1         = '{ent: h, valid: hv};
    pn         = have_add ? 2'd1 : 2'd0;
    dec_done   = 1'b0;
    dec_lost   = 1'b0;
    dec_status = ST_OK;
    cnt_dec    = 1'b0;
    cnt_inc    = 1'b0;
    set_grant  = 1'b0;
    at_pos     = 1'b0;
    prevm      = 1'b0;
    nextm      = 1'b0;
    if (state == S_RUN && !done) begin
      unique case (op)
        OP_ALLOC: begin
          if (hv && h.len >= size) begin
            set_grant    = 1'b1;
            dec_done     = 1'b1;
            p0.ent.start = h.start + size;
            p0.ent.len   = h.len - size;
            if (h.len == size) begin
              pn      = 2'd0;
              cnt_dec = 1'b1;
            end
          end
        end
        OP_FREE: begin
          at_pos = (step >= cnt) || (h.start > addr);
          prevm  = pop && (q0.ent.start + q0.ent.len == addr);
          nextm  = hv && (addr + size == h.start);
          if (at_pos) begin
            dec_done = 1'b1;
            if (prevm) begin
              // merge into the preceding region, maybe absorbing the next
              q0m.ent.len = q0.ent.len + size + (nextm ? h.len : '0);
              if (nextm) begin
                pn      = 2'd0;
                cnt_dec = 1'b1;
              end
            end else if (nextm) begin
              p0.ent.start = addr;
              p0.ent.len   = h.len + size;
            end else if (cnt < LAST) begin
              p0      = '{ent: '{start: addr, len: size}, valid: 1'b1};
              pn      = 2'd2;
              cnt_inc = 1'b1;
            end else begin
              dec_lost   = 1'b1;
              dec_status = ST_FULL;
            end
          end
        end
        default: ;
      endcase
    end
    for (int k = 0; k < 4; k++) begin
      if (k < int'(qn)) begin
        lst[k] = (k == 0) ? q0m : q1;
      end else begin
        lst[k] = (k == int'(qn)) ? p0 : p1;
      end
    end
    ln    = 3'(qn) + 3'(pn);
    tail  = lst[0].ent;
    shift = (state == S_RUN);
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_RUN;
      S_RUN:   if (step == LAST) state_next = S_SUM;
      S_SUM:   state_next = S_OUT;
      S_OUT:   if (!out_v || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      peak   <= '0;
      lost_n <= '0;
      lost_b <= '0;
      out_v  <= 1'b0;
      done   <= 1'b0;
      acc_v  <= 1'b0;
      qn     <= '0;
      step   <= '0;
    end else begin
      // a new result replaces a taken one in the same cycle
      if (state == S_OUT && (!out_v || rsp.ready)) begin
        out_v <= 1'b1;
      end else if (out_v && rsp.ready) begin
        out_v <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            step    <= '0;
            qn      <= '0;
            acc_v   <= 1'b0;
            new_cnt <= cnt;
            sum     <= '0;
            status  <= ST_OK;
            grant   <= '0;
            op      <= req.operation;
            addr    <= req.block_address;
            size    <= size_in;
            // queries and zero-byte frees change nothing
            done    <= !(req.operation == OP_ALLOC ||
                         (req.operation == OP_FREE && size_in != '0));
          end
        end
        S_RUN: begin
          step <= step + 1'b1;
          if (pop) begin
            q0 <= lst[1];
            q1 <= lst[2];
            qn <= 2'(ln - 3'd1);
          end else begin
            q0 <= lst[0];
            q1 <= lst[1];
            qn <= 2'(ln);
          end
          acc_len <= tail.len;
          acc_v   <= pop && lst[0].valid;
          if (acc_v) begin
            sum <= sat_add(sum, acc_len);
          end
          if (dec_done) begin
            done   <= 1'b1;
            status <= dec_status;
          end
          if (set_grant) begin
            grant <= h.start;
          end
          if (cnt_dec) begin
            new_cnt <= new_cnt - 1'b1;
          end
          if (cnt_inc) begin
            new_cnt <= new_cnt + 1'b1;
          end
          if (dec_lost) begin
            if (lost_n != SAT32) begin
              lost_n <= lost_n + 1'b1;
            end
            lost_b <= sat_add(lost_b, size);
          end
        end
        S_SUM: begin
          if (acc_v) begin
            sum <= sat_add(sum, acc_len);
          end
          acc_v <= 1'b0;
          cnt   <= new_cnt;
          if (peak < new_cnt) begin
            peak <= new_cnt;
          end
          if (!done) begin
            status <= ST_NOFIT;
          end
        end
        default: ;
      endcase
    end
  end

  // result payload, loaded as the item leaves the pass
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_v || rsp.ready)) begin
      o_status <= status;
      o_grant  <= grant;
      o_sum    <= sum;
      o_cnt    <= cnt;
      o_peak   <= peak;
      o_lost_n <= lost_n;
      o_lost_b <= lost_b;
    end
  end

  assign rsp.valid           = out_v;
  assign rsp.status          = o_status;
  assign rsp.granted_address = o_grant;
  assign rsp.free_total      = o_sum;
  assign rsp.entries_used    = CNT_OUT_W'(o_cnt);
  assign rsp.peak_entries    = CNT_OUT_W'(o_peak);
  assign rsp.lost_blocks     = o_lost_n;
  assign rsp.lost_bytes      = o_lost_b;

endmodule
